// ===== hdl/indexed_max_priority_store_defines.svh =====
// Assertion macros for the RTL of the priority store.
`ifndef INDEXED_MAX_PRIORITY_STORE_DEFINES_SVH
`define INDEXED_MAX_PRIORITY_STORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define IMPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define IMPS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/imps_pkg.sv =====
package imps_pkg;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 32;

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_POLL = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ID_W-1:0]   event_id;
    logic [PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] polled_id;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/indexed_max_priority_store.sv =====
// Indexed max-priority store. The block keeps one priority per event id and a
// live mark per id. A set transfer (kind = set) writes the priority of the
// given id and marks it live; it produces no result, and an id at or above
// ID_LIMIT is ignored. A poll transfer scans all stored ids in ascending order
// with a single 32-bit comparator fed from the one read port of the priority
// memory, one id per cycle, picks the live event with the largest priority (the
// smallest id wins a tie), clears its live mark and returns its id with
// found = 1. A poll of an empty table returns found = 0 and polled_id = 0
// without scanning, going straight to the done state. A poll of a non-empty
// table passes through the scan, last and done states before the result is
// loaded into the output register; the scan covers DEPTH ids, where DEPTH is
// the smaller of ID_LIMIT and 256. The input side is ready only while the
// sequencer is idle; a finished result waits in the output register so that
// set transfers can keep arriving while the consumer stalls. Live marks are
// cleared by reset; priority entries are not, and an entry's value is used
// only after it has been written.
`include "indexed_max_priority_store_defines.svh"

module indexed_max_priority_store #(
  parameter int ID_LIMIT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output imps_pkg::out_item_t out_data
);

  // Ids beyond 255 cannot be carried by the 8-bit id field, so storage stops there.
  localparam int DEPTH = (ID_LIMIT < (1 << imps_pkg::ID_W)) ? ID_LIMIT : (1 << imps_pkg::ID_W);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  imps_pkg::state_t state_r;
  imps_pkg::state_t state_nxt;

  logic [DEPTH-1:0]            live_r;
  logic [CNT_W-1:0]            live_count_r;
  logic [imps_pkg::PRIO_W-1:0] prio_mem [DEPTH];
  logic [imps_pkg::PRIO_W-1:0] prio_rd_r;

  logic [IDX_W-1:0]            scan_idx_r;
  logic                        cand_vld_r;
  logic                        cand_live_r;
  logic [IDX_W-1:0]            cand_id_r;

  logic                        have_r;
  logic [IDX_W-1:0]            best_id_r;
  logic [imps_pkg::PRIO_W-1:0] best_prio_r;

  logic                        out_valid_r;
  imps_pkg::out_item_t         out_r;

  logic             in_xfer;
  logic             set_xfer;
  logic             poll_xfer;
  logic             set_in_range;
  logic [IDX_W-1:0] set_idx;
  logic             out_load;
  logic             scan_last;
  logic             cand_wins;

  assign in_ready     = (state_r == imps_pkg::ST_IDLE);
  assign in_xfer      = in_valid && in_ready;
  assign set_in_range = (32'(in_data.event_id) < 32'(ID_LIMIT));
  assign set_idx      = in_data.event_id[IDX_W-1:0];
  assign set_xfer     = in_xfer && (in_data.kind == imps_pkg::KIND_SET) && set_in_range;
  assign poll_xfer    = in_xfer && (in_data.kind == imps_pkg::KIND_POLL);
  assign scan_last    = (scan_idx_r == IDX_W'(DEPTH - 1));
  assign out_load     = (state_r == imps_pkg::ST_DONE) && (!out_valid_r || out_ready);

  // One comparator: the candidate read last cycle against the best so far.
  // Strictly greater keeps the smaller id on a tie, since ids rise during the scan.
  assign cand_wins = cand_vld_r && cand_live_r && (!have_r || (prio_rd_r > best_prio_r));

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state. An empty table skips the scan entirely.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      imps_pkg::ST_IDLE: begin
        if (poll_xfer) begin
          state_nxt = (live_count_r == '0) ? imps_pkg::ST_DONE : imps_pkg::ST_SCAN;
        end
      end
      imps_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = imps_pkg::ST_LAST;
        end
      end
      imps_pkg::ST_LAST: begin
        state_nxt = imps_pkg::ST_DONE;
      end
      imps_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = imps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = imps_pkg::ST_IDLE;
      end
    endcase
  end

  // Priority memory: written by set transfers, read at the scan address.
  always_ff @(posedge clk) begin
    if (set_xfer) begin
      prio_mem[set_idx] <= in_data.priority_req;
    end
    prio_rd_r <= prio_mem[scan_idx_r];
  end

  // Scan address and the candidate that travels alongside the memory read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      cand_vld_r <= 1'b0;
    end else begin
      cand_vld_r <= (state_r == imps_pkg::ST_SCAN);
      if (poll_xfer) begin
        scan_idx_r <= '0;
      end else if (state_r == imps_pkg::ST_SCAN && !scan_last) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cand_live_r <= live_r[scan_idx_r];
    cand_id_r   <= scan_idx_r;
  end

  // Running best of the scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (poll_xfer) begin
      have_r <= 1'b0;
    end else if (cand_wins) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cand_wins) begin
      best_id_r   <= cand_id_r;
      best_prio_r <= prio_rd_r;
    end
  end

  // Live marks and the live count. A set and a removal never share a cycle,
  // because sets are only taken while the sequencer is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r       <= '0;
      live_count_r <= '0;
    end else if (set_xfer) begin
      if (!live_r[set_idx]) begin
        live_r[set_idx] <= 1'b1;
        live_count_r    <= live_count_r + CNT_W'(1);
      end
    end else if (out_load && have_r) begin
      live_r[best_id_r] <= 1'b0;
      live_count_r      <= live_count_r - CNT_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.found     <= have_r;
      out_r.polled_id <= have_r ? imps_pkg::ID_W'(best_id_r) : '0;
    end
  end

  // The count and the marks must agree on an empty table.
  `IMPS_ASSERT_NOW(a_count_matches_marks, clk, rst_n, 1'b1, ((live_count_r == '0) == (live_r == '0)))
  `IMPS_ASSERT_NOW(a_count_bounded, clk, rst_n, 1'b1, (live_count_r <= CNT_W'(DEPTH)))
  `IMPS_ASSERT_NEXT(a_poll_leaves_idle, clk, rst_n, poll_xfer, (state_r != imps_pkg::ST_IDLE))
  `IMPS_ASSERT_NEXT(a_done_loads_result, clk, rst_n, out_load, (out_valid_r && state_r == imps_pkg::ST_IDLE))

endmodule
